// ===== design/table_driven_swizzle_address_gen_assert.svh =====
// Assertion macros shared by the swizzle address generator modules.
// The macros expect signals named clk and rst_n in the using module.
`ifndef TABLE_DRIVEN_SWIZZLE_ADDRESS_GEN_ASSERT_SVH
`define TABLE_DRIVEN_SWIZZLE_ADDRESS_GEN_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define TDSAG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TDSAG_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TDSAG_ASSERT(lbl, prop, msg)
`define TDSAG_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== design/tdsag_pkg.sv =====
// Shared types, codes and sizes for the swizzle address generator.
// No dependencies.
`timescale 1ns / 1ps
package tdsag_pkg;

  localparam int TABLE_DEPTH_DEF = 256;
  localparam int ADDR_W          = 35;
  localparam int OFS_W           = 32;
  localparam int CNT_W           = 9;
  localparam int NUM_TABLES      = 4;

  // result queue depth, power of two
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);
  localparam int QSW    = QCW + 1;

  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_ADVANCE = 1'b1;

  localparam logic [1:0] TSEL_CHANNEL = 2'd0;
  localparam logic [1:0] TSEL_COLUMN  = 2'd1;
  localparam logic [1:0] TSEL_ROW     = 2'd2;
  localparam logic [1:0] TSEL_DEPTH   = 2'd3;

  localparam logic [2:0] CFG_DIRECTION    = 3'd0;
  localparam logic [2:0] CFG_ELEM_LOG2    = 3'd1;
  localparam logic [2:0] CFG_CHANNEL_CNT  = 3'd2;
  localparam logic [2:0] CFG_COLUMN_CNT   = 3'd3;
  localparam logic [2:0] CFG_ROW_CNT      = 3'd4;
  localparam logic [2:0] CFG_DEPTH_CNT    = 3'd5;

  typedef struct packed {
    logic       direction;
    logic [1:0] elem_log2;
  } cfg_t;

  typedef struct packed {
    logic       en;
    logic [1:0] sel;
  } ld_t;

  typedef struct packed {
    logic [2:0]        byte_cnt;
    logic [ADDR_W-1:0] lin;
    logic              last;
  } meta_t;

  typedef struct packed {
    logic  valid;
    meta_t meta;
  } issue_t;

  typedef struct packed {
    logic [ADDR_W-1:0] src;
    logic [ADDR_W-1:0] dst;
    logic              last;
  } res_t;

endpackage

// ===== design/table_driven_swizzle_address_gen.sv =====
// Swizzle address generator: one byte address pair per advance transfer, none per load.
// Advance: issue and table read registers, result queue, output register; loads act at once.
// Throughput: one transfer per cycle; the 4-entry result queue stalls input only on back-pressure.
// Reset (rst_n low, synchronous): counters and linear address to zero, direction 0,
// element size 1 byte, all counts 1; offset tables hold no reset value until loaded.
// Depends on tdsag_pkg, tdsag_front, tdsag_tables, tdsag_back.
`timescale 1ns / 1ps
module table_driven_swizzle_address_gen import tdsag_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [CNT_W-1:0]  cfg_wdata,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_cmd,
  input  logic [1:0]        in_table_select,
  input  logic [7:0]        in_entry_index,
  input  logic [OFS_W-1:0]  in_entry_value,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [ADDR_W-1:0] out_source_addr,
  output logic [ADDR_W-1:0] out_dest_addr,
  output logic              out_last
);

  localparam int CW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  cfg_t                            cfg;
  ld_t                             ld;
  logic [CW-1:0]                   wr_addr;
  logic [OFS_W-1:0]                wr_data;
  logic                            rd_en;
  logic [NUM_TABLES-1:0][CW-1:0]   rd_addr;
  logic [NUM_TABLES-1:0][OFS_W-1:0] rd_data;
  issue_t                          iss;
  logic [QCW-1:0]                  q_count;

  tdsag_front #(.TABLE_DEPTH(TABLE_DEPTH)) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_cmd          (in_cmd),
    .in_table_select (in_table_select),
    .in_entry_index  (in_entry_index),
    .in_entry_value  (in_entry_value),
    .q_count         (q_count),
    .cfg_o           (cfg),
    .ld_o            (ld),
    .wr_addr         (wr_addr),
    .wr_data         (wr_data),
    .rd_en           (rd_en),
    .rd_addr         (rd_addr),
    .iss_o           (iss)
  );

  tdsag_tables #(.TABLE_DEPTH(TABLE_DEPTH)) u_tables (
    .clk     (clk),
    .ld      (ld),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  tdsag_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg),
    .iss             (iss),
    .rd_data         (rd_data),
    .q_count         (q_count),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_source_addr (out_source_addr),
    .out_dest_addr   (out_dest_addr),
    .out_last        (out_last)
  );

endmodule

// ===== design/tdsag_front.sv =====
// Front end: config registers, input transfer decode, walk counters, table load/read issue.
// Depends on tdsag_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "table_driven_swizzle_address_gen_assert.svh"
module tdsag_front import tdsag_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  localparam int CW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [2:0]                 cfg_index,
  input  logic [CNT_W-1:0]           cfg_wdata,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_cmd,
  input  logic [1:0]                 in_table_select,
  input  logic [7:0]                 in_entry_index,
  input  logic [OFS_W-1:0]           in_entry_value,
  input  logic [QCW-1:0]             q_count,
  output cfg_t                       cfg_o,
  output ld_t                        ld_o,
  output logic [CW-1:0]              wr_addr,
  output logic [OFS_W-1:0]           wr_data,
  output logic                       rd_en,
  output logic [NUM_TABLES-1:0][CW-1:0] rd_addr,
  output issue_t                     iss_o
);

  localparam logic [12:0] TD13 = 13'(TABLE_DEPTH);

  logic             dir_r;
  logic [1:0]       elog2_r;
  logic [CNT_W-1:0] ch_cnt_r, co_cnt_r, ro_cnt_r, de_cnt_r;

  logic [2:0]        byte_r, byte_nxt;
  logic [CW-1:0]     ch_r, ch_nxt, co_r, co_nxt, ro_r, ro_nxt, de_r, de_nxt;
  logic [ADDR_W-1:0] lin_r, lin_nxt;
  issue_t            iss_r;

  logic          acc, adv, last;
  logic          c_byte, c_ch, c_co, c_ro, c_de;
  logic [2:0]    byte_fin;
  logic [CW-1:0] ch_fin, co_fin, ro_fin, de_fin;

  function automatic logic [CW-1:0] fin_of(input logic [CNT_W-1:0] n);
    logic [12:0] n13;
    n13 = {4'b0000, n};
    if (n13 == 13'd0) begin
      return '0;
    end else if (n13 > TD13) begin
      return CW'(TD13 - 13'd1);
    end else begin
      return CW'(n13 - 13'd1);
    end
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r    <= 1'b0;
      elog2_r  <= 2'd0;
      ch_cnt_r <= 9'd1;
      co_cnt_r <= 9'd1;
      ro_cnt_r <= 9'd1;
      de_cnt_r <= 9'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DIRECTION:   dir_r    <= cfg_wdata[0];
        CFG_ELEM_LOG2:   elog2_r  <= cfg_wdata[1:0];
        CFG_CHANNEL_CNT: ch_cnt_r <= cfg_wdata;
        CFG_COLUMN_CNT:  co_cnt_r <= cfg_wdata;
        CFG_ROW_CNT:     ro_cnt_r <= cfg_wdata;
        CFG_DEPTH_CNT:   de_cnt_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg_o.direction = dir_r;
  assign cfg_o.elem_log2 = elog2_r;

  // room for everything in flight, counted from registers only
  assign in_stall = (QSW'(q_count) + QSW'(iss_r.valid)) >= QSW'(QDEPTH);

  assign acc = in_valid && !in_stall;
  assign adv = acc && (in_cmd == CMD_ADVANCE);

  assign byte_fin = 3'((4'd1 << elog2_r) - 4'd1);
  assign ch_fin   = fin_of(ch_cnt_r);
  assign co_fin   = fin_of(co_cnt_r);
  assign ro_fin   = fin_of(ro_cnt_r);
  assign de_fin   = fin_of(de_cnt_r);

  assign c_byte = byte_r >= byte_fin;
  assign c_ch   = ch_r >= ch_fin;
  assign c_co   = co_r >= co_fin;
  assign c_ro   = ro_r >= ro_fin;
  assign c_de   = de_r >= de_fin;
  assign last   = c_byte && c_ch && c_co && c_ro && c_de;

  always_comb begin
    byte_nxt = byte_r;
    ch_nxt   = ch_r;
    co_nxt   = co_r;
    ro_nxt   = ro_r;
    de_nxt   = de_r;
    lin_nxt  = lin_r;
    if (adv) begin
      if (last) begin
        byte_nxt = '0;
        ch_nxt   = '0;
        co_nxt   = '0;
        ro_nxt   = '0;
        de_nxt   = '0;
        lin_nxt  = '0;
      end else begin
        lin_nxt  = lin_r + ADDR_W'(1);
        byte_nxt = c_byte ? 3'd0 : byte_r + 3'd1;
        if (c_byte) begin
          ch_nxt = c_ch ? '0 : ch_r + CW'(1);
          if (c_ch) begin
            co_nxt = c_co ? '0 : co_r + CW'(1);
            if (c_co) begin
              ro_nxt = c_ro ? '0 : ro_r + CW'(1);
              if (c_ro) begin
                de_nxt = c_de ? '0 : de_r + CW'(1);
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_r      <= '0;
      ch_r        <= '0;
      co_r        <= '0;
      ro_r        <= '0;
      de_r        <= '0;
      lin_r       <= '0;
      iss_r.valid <= 1'b0;
    end else begin
      byte_r      <= byte_nxt;
      ch_r        <= ch_nxt;
      co_r        <= co_nxt;
      ro_r        <= ro_nxt;
      de_r        <= de_nxt;
      lin_r       <= lin_nxt;
      iss_r.valid <= adv;
      if (adv) begin
        iss_r.meta.byte_cnt <= byte_r;
        iss_r.meta.lin      <= lin_r;
        iss_r.meta.last     <= last;
      end
    end
  end

  assign iss_o = iss_r;

  assign ld_o.en  = acc && (in_cmd == CMD_LOAD) && ({5'b00000, in_entry_index} < TD13);
  assign ld_o.sel = in_table_select;
  assign wr_addr  = CW'(in_entry_index);
  assign wr_data  = in_entry_value;

  assign rd_en = adv;
  assign rd_addr[TSEL_CHANNEL] = ch_r;
  assign rd_addr[TSEL_COLUMN]  = co_r;
  assign rd_addr[TSEL_ROW]     = ro_r;
  assign rd_addr[TSEL_DEPTH]   = de_r;

  `TDSAG_ASSERT(a_last_clears, (adv && last) |=> (lin_r == '0 && byte_r == '0 && ch_r == '0 && co_r == '0 && ro_r == '0 && de_r == '0), "walk did not restart after last byte")
  `TDSAG_ASSERT(a_lin_step, (adv && !last) |=> (lin_r == ADDR_W'($past(lin_r) + ADDR_W'(1))), "linear address did not step")
  `TDSAG_ASSERT(a_issue, adv |=> iss_r.valid, "advance transfer not issued")

endmodule

// ===== design/tdsag_tables.sv =====
// Four offset tables (channel, column, row, depth), one write and one read port each.
// Depends on tdsag_pkg.
`timescale 1ns / 1ps
module tdsag_tables import tdsag_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  localparam int CW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  logic                           clk,
  input  ld_t                            ld,
  input  logic [CW-1:0]                  wr_addr,
  input  logic [OFS_W-1:0]               wr_data,
  input  logic                           rd_en,
  input  logic [NUM_TABLES-1:0][CW-1:0]  rd_addr,
  output logic [NUM_TABLES-1:0][OFS_W-1:0] rd_data
);

  for (genvar g = 0; g < NUM_TABLES; g++) begin : g_tab
    logic [OFS_W-1:0] mem [TABLE_DEPTH];
    logic [OFS_W-1:0] q_r;

    always_ff @(posedge clk) begin
      if (ld.en && (ld.sel == 2'(g))) begin
        mem[wr_addr] <= wr_data;
      end
    end

    always_ff @(posedge clk) begin
      if (rd_en) begin
        q_r <= mem[rd_addr[g]];
      end
    end

    assign rd_data[g] = q_r;
  end

endmodule

// ===== design/tdsag_back.sv =====
// Back end: offset sum, byte address forming, result queue and output register.
// Depends on tdsag_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "table_driven_swizzle_address_gen_assert.svh"
module tdsag_back import tdsag_pkg::*; (
  input  logic                           clk,
  input  logic                           rst_n,
  input  cfg_t                           cfg,
  input  issue_t                         iss,
  input  logic [NUM_TABLES-1:0][OFS_W-1:0] rd_data,
  output logic [QCW-1:0]                 q_count,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [ADDR_W-1:0]              out_source_addr,
  output logic [ADDR_W-1:0]              out_dest_addr,
  output logic                           out_last
);

  logic [OFS_W-1:0]  sum;
  logic [ADDR_W-1:0] swz;
  res_t              res;

  res_t           fifo_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCW-1:0] count_r, count_nxt;
  logic           push, pop;
  logic           out_valid_r, out_valid_nxt;
  res_t           out_r;

  assign sum = rd_data[0] + rd_data[1] + rd_data[2] + rd_data[3];
  assign swz = ADDR_W'(({3'b000, sum} << cfg.elem_log2) + ADDR_W'(iss.meta.byte_cnt));

  always_comb begin
    if (cfg.direction) begin
      res.src = iss.meta.lin;
      res.dst = swz;
    end else begin
      res.src = swz;
      res.dst = iss.meta.lin;
    end
    res.last = iss.meta.last;
  end

  assign push = iss.valid;
  assign pop  = (count_r != '0) && (!out_valid_r || !out_stall);

  always_comb begin
    case ({push, pop})
      2'b10:   count_nxt = count_r + QCW'(1);
      2'b01:   count_nxt = count_r - QCW'(1);
      default: count_nxt = count_r;
    endcase
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QAW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QAW'(1);
      end
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= res;
    end
    if (pop) begin
      out_r <= fifo_r[rd_ptr_r];
    end
  end

  assign q_count         = count_r;
  assign out_valid       = out_valid_r;
  assign out_source_addr = out_r.src;
  assign out_dest_addr   = out_r.dst;
  assign out_last        = out_r.last;

  `TDSAG_ASSERT(a_no_overflow, !(push && !pop && count_r == QCW'(QDEPTH)), "result queue overflow")
  `TDSAG_ASSERT(a_empty_ptrs, (count_r == '0) |-> (wr_ptr_r == rd_ptr_r), "queue pointers disagree with count")
  `TDSAG_ASSERT(a_push_fills, push |=> (count_r != '0 || out_valid_r), "pushed result lost")

endmodule

// ===== verif/swizzle_addr_checker.sv =====
// Checker for the swizzle address generator: mirrors the config port and the four offset
// tables, predicts every byte address pair and compares it with the result channel.
// Depends on tdsag_pkg.
`timescale 1ns / 1ps
module swizzle_addr_checker import tdsag_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [CNT_W-1:0]  cfg_wdata,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic              in_cmd,
  input  logic [1:0]        in_table_select,
  input  logic [7:0]        in_entry_index,
  input  logic [OFS_W-1:0]  in_entry_value,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [ADDR_W-1:0] out_source_addr,
  input  logic [ADDR_W-1:0] out_dest_addr,
  input  logic              out_last,
  output int                mismatches,
  output int                outstanding
);

  logic [OFS_W-1:0]  ofs_tab [NUM_TABLES][TABLE_DEPTH_DEF];
  logic              swizzle_dir;
  logic [1:0]        elem_log2;
  logic [CNT_W-1:0]  ch_cnt, co_cnt, ro_cnt, de_cnt;
  logic [2:0]        byte_pos;
  logic [7:0]        ch_pos, co_pos, ro_pos, de_pos;
  logic [ADDR_W-1:0] lin_addr;
  res_t              pending_pairs[$];

  // count 0 acts as 1, anything above the table depth as the full table
  function automatic logic [7:0] final_pos(input logic [CNT_W-1:0] cnt);
    if (cnt == 0) return 8'd0;
    if (cnt > TABLE_DEPTH_DEF) return 8'd255;
    return cnt[7:0] - 8'd1;
  endfunction

  task automatic predict_pair();
    logic [2:0]        byte_fin;
    logic [7:0]        ch_fin, co_fin, ro_fin, de_fin;
    logic [OFS_W-1:0]  sum;
    logic [ADDR_W-1:0] swz;
    res_t              pair;
    byte_fin = (3'd1 << elem_log2) - 3'd1;
    ch_fin = final_pos(ch_cnt);
    co_fin = final_pos(co_cnt);
    ro_fin = final_pos(ro_cnt);
    de_fin = final_pos(de_cnt);
    sum = ofs_tab[TSEL_DEPTH][de_pos] + ofs_tab[TSEL_ROW][ro_pos]
        + ofs_tab[TSEL_COLUMN][co_pos] + ofs_tab[TSEL_CHANNEL][ch_pos];
    swz = ({3'd0, sum} << elem_log2) + {32'd0, byte_pos};
    pair.last = byte_pos >= byte_fin && ch_pos >= ch_fin && co_pos >= co_fin &&
                ro_pos >= ro_fin && de_pos >= de_fin;
    pair.src = swizzle_dir ? lin_addr : swz;
    pair.dst = swizzle_dir ? swz : lin_addr;
    pending_pairs.push_back(pair);
    if (byte_pos >= byte_fin) begin
      byte_pos = '0;
      if (ch_pos >= ch_fin) begin
        ch_pos = '0;
        if (co_pos >= co_fin) begin
          co_pos = '0;
          if (ro_pos >= ro_fin) begin
            ro_pos = '0;
            if (de_pos >= de_fin) de_pos = '0;
            else de_pos = de_pos + 8'd1;
          end else begin
            ro_pos = ro_pos + 8'd1;
          end
        end else begin
          co_pos = co_pos + 8'd1;
        end
      end else begin
        ch_pos = ch_pos + 8'd1;
      end
    end else begin
      byte_pos = byte_pos + 3'd1;
    end
    if (pair.last) begin
      byte_pos = '0;
      ch_pos = '0;
      co_pos = '0;
      ro_pos = '0;
      de_pos = '0;
      lin_addr = '0;
    end else begin
      lin_addr = lin_addr + 1'b1;
    end
  endtask

  always @(posedge clk) begin : monitor
    res_t want;
    int   bad;
    bad = 0;
    if (!rst_n) begin
      swizzle_dir = 1'b0;
      elem_log2 = 2'd0;
      ch_cnt = 9'd1;
      co_cnt = 9'd1;
      ro_cnt = 9'd1;
      de_cnt = 9'd1;
      byte_pos = '0;
      ch_pos = '0;
      co_pos = '0;
      ro_pos = '0;
      de_pos = '0;
      lin_addr = '0;
      pending_pairs.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_DIRECTION:   swizzle_dir = cfg_wdata[0];
          CFG_ELEM_LOG2:   elem_log2 = cfg_wdata[1:0];
          CFG_CHANNEL_CNT: ch_cnt = cfg_wdata;
          CFG_COLUMN_CNT:  co_cnt = cfg_wdata;
          CFG_ROW_CNT:     ro_cnt = cfg_wdata;
          CFG_DEPTH_CNT:   de_cnt = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        if (in_cmd == CMD_LOAD) ofs_tab[in_table_select][in_entry_index] = in_entry_value;
        else predict_pair();
      end
      if (out_valid && !out_stall) begin
        if (pending_pairs.size() == 0) begin
          $display("%0t: unexpected transfer src=%h dst=%h last=%b", $time,
                   out_source_addr, out_dest_addr, out_last);
          bad++;
        end else begin
          want = pending_pairs.pop_front();
          if (out_source_addr !== want.src) begin
            $display("%0t: source_addr expected %h got %h", $time, want.src, out_source_addr);
            bad++;
          end
          if (out_dest_addr !== want.dst) begin
            $display("%0t: dest_addr expected %h got %h", $time, want.dst, out_dest_addr);
            bad++;
          end
          if (out_last !== want.last) begin
            $display("%0t: last expected %b got %b", $time, want.last, out_last);
            bad++;
          end
        end
      end
    end
    mismatches <= (!rst_n) ? 0 : mismatches + bad;
    outstanding <= pending_pairs.size();
  end

endmodule

// ===== verif/tb_table_driven_swizzle_address_gen.sv =====
// Top of the swizzle address generator testbench: clock, reset, config writes and
// load/advance stimulus with random gaps and stalls; verdict from swizzle_addr_checker.
// Depends on tdsag_pkg, table_driven_swizzle_address_gen and swizzle_addr_checker.
`timescale 1ns / 1ps
module tb_table_driven_swizzle_address_gen;
  import tdsag_pkg::*;

  localparam int HOLD_CYCLES   = 200;
  localparam int STUCK_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASES        = 12;
  localparam int PHASE_ITEMS   = 42;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_we;
  logic [2:0]        cfg_index;
  logic [CNT_W-1:0]  cfg_wdata;
  logic              in_valid;
  logic              in_stall;
  logic              in_cmd;
  logic [1:0]        in_table_select;
  logic [7:0]        in_entry_index;
  logic [OFS_W-1:0]  in_entry_value;
  logic              out_valid;
  logic              out_stall;
  logic [ADDR_W-1:0] out_source_addr;
  logic [ADDR_W-1:0] out_dest_addr;
  logic              out_last;
  int                mismatches;
  int                outstanding;
  int                gap_pct;
  int                stall_pct;
  logic              hold_go;
  int                stuck_cycles = 0;

  always #4 clk = ~clk;

  table_driven_swizzle_address_gen uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_cmd          (in_cmd),
    .in_table_select (in_table_select),
    .in_entry_index  (in_entry_index),
    .in_entry_value  (in_entry_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_source_addr (out_source_addr),
    .out_dest_addr   (out_dest_addr),
    .out_last        (out_last)
  );

  swizzle_addr_checker pair_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_cmd          (in_cmd),
    .in_table_select (in_table_select),
    .in_entry_index  (in_entry_index),
    .in_entry_value  (in_entry_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_source_addr (out_source_addr),
    .out_dest_addr   (out_dest_addr),
    .out_last        (out_last),
    .mismatches      (mismatches),
    .outstanding     (outstanding)
  );

  task automatic put_item(input logic cmd, input logic [1:0] sel, input logic [7:0] idx,
                          input logic [OFS_W-1:0] val);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_table_select <= sel;
    in_entry_index <= idx;
    in_entry_value <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // loads give no result, so let the pipeline run dry before touching config
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_shape(input logic dir, input logic [1:0] lg,
                           input logic [CNT_W-1:0] ch, input logic [CNT_W-1:0] co,
                           input logic [CNT_W-1:0] ro, input logic [CNT_W-1:0] de);
    cfg_we <= 1'b1;
    cfg_index <= CFG_DIRECTION;
    cfg_wdata <= {8'd0, dir};
    @(posedge clk);
    cfg_index <= CFG_ELEM_LOG2;
    cfg_wdata <= {7'd0, lg};
    @(posedge clk);
    cfg_index <= CFG_CHANNEL_CNT;
    cfg_wdata <= ch;
    @(posedge clk);
    cfg_index <= CFG_COLUMN_CNT;
    cfg_wdata <= co;
    @(posedge clk);
    cfg_index <= CFG_ROW_CNT;
    cfg_wdata <= ro;
    @(posedge clk);
    cfg_index <= CFG_DEPTH_CNT;
    cfg_wdata <= de;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // mostly short walks so the last byte comes round often
  function automatic logic [CNT_W-1:0] pick_count();
    int               r;
    logic [CNT_W-1:0] n;
    r = $urandom_range(99);
    if (r < 8) n = 9'd0;
    else if (r < 13) n = 9'd256;
    else if (r < 16) n = 9'($urandom_range(511, 257));
    else if (r < 50) n = 9'd1;
    else n = 9'($urandom_range(4, 2));
    return n;
  endfunction

  initial begin : receiver
    bit held;
    held = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go && !held) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) stuck_cycles <= 0;
    else stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_DIRECTION;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_cmd = CMD_LOAD;
    in_table_select = TSEL_CHANNEL;
    in_entry_index = '0;
    in_entry_value = '0;
    gap_pct = 0;
    stall_pct = 0;
    hold_go = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // every entry loaded up front, so no walk can hit an unloaded one
    for (int t = 0; t < NUM_TABLES; t++)
      for (int i = 0; i < TABLE_DEPTH_DEF; i++)
        put_item(CMD_LOAD, 2'(t), 8'(i), $urandom());
    settle();

    // all-ones offsets in three tables: sum wraps, 8-byte elements fill all 35 bits
    set_shape(1'b1, 2'd3, 9'd1, 9'd1, 9'd1, 9'd1);
    put_item(CMD_LOAD, TSEL_CHANNEL, 8'd0, '1);
    put_item(CMD_LOAD, TSEL_COLUMN, 8'd0, '1);
    put_item(CMD_LOAD, TSEL_ROW, 8'd0, '1);
    put_item(CMD_LOAD, TSEL_DEPTH, 8'd255, '1);
    repeat (8) put_item(CMD_ADVANCE, TSEL_DEPTH, 8'd255, '1);
    settle();

    // zero count acts as one, oversized count as the full table
    set_shape(1'b0, 2'd0, 9'd0, 9'd256, 9'd511, 9'd1);
    put_item(CMD_LOAD, TSEL_COLUMN, 8'd1, '0);
    put_item(CMD_LOAD, TSEL_ROW, 8'd0, 32'h8000_0001);
    repeat (3) put_item(CMD_ADVANCE, TSEL_CHANNEL, 8'd0, '0);
    settle();

    // column counter now past the new count: taken as final, walk ends at once
    set_shape(1'b0, 2'd0, 9'd0, 9'd2, 9'd1, 9'd1);
    repeat (2) put_item(CMD_ADVANCE, TSEL_CHANNEL, 8'd0, '0);

    for (int p = 0; p < PHASES; p++) begin
      settle();
      set_shape(1'($urandom_range(1)), 2'($urandom_range(3)), pick_count(), pick_count(),
                pick_count(), pick_count());
      gap_pct = (p < 4) ? 18 : (p < 8) ? 80 : 0;
      stall_pct = (p < 4) ? 80 : (p < 8) ? 18 : 0;
      if (p == 8) hold_go = 1'b1;
      repeat (PHASE_ITEMS)
        put_item(($urandom_range(99) < 80) ? CMD_ADVANCE : CMD_LOAD, 2'($urandom_range(3)),
                 8'($urandom_range(255)), $urandom());
    end
    settle();

    if (mismatches == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
